### rtl/prime_factorizer_assert.svh
// assertion macros shared by the prime factorizer rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PRIME_FACTORIZER_ASSERT_SVH
`define PRIME_FACTORIZER_ASSERT_SVH

// same-cycle implication
`define PF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pf_pkg.sv
// shared types, constants and elaboration helpers of the prime factorizer
// no dependencies
`timescale 1ns / 1ps

package pf_pkg;

  localparam int VALUE_W          = 32;
  localparam int TRIAL_W          = 16;
  localparam int CNT_W            = $clog2(VALUE_W);
  localparam int WHEEL_W          = 3;
  localparam int TABLE_DEPTH      = 6542;
  localparam int PRIME_COUNT_DEF  = 6542;
  localparam int SIEVE_SIZE       = 65536;
  localparam int SIEVE_ROOT       = 256;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [TRIAL_W-1:0] trial_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [WHEEL_W-1:0] wheel_t;

  localparam trial_t FIRST_TRIAL = trial_t'(2);
  localparam trial_t WHEEL_START = trial_t'(7);
  localparam trial_t LAST_PRIME  = trial_t'(65521);
  localparam value_t ONE_VALUE   = value_t'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic init;
    logic step;
  } trial_ctrl_t;

  typedef struct packed {
    logic   done;
    logic   exact;
    logic   below;
    value_t quo;
  } div_res_t;

  // gaps between numbers coprime to 30, starting at 7
  function automatic trial_t wheel_step(wheel_t idx);
    trial_t gap;
    case (idx)
      3'd0:    gap = trial_t'(4);
      3'd1:    gap = trial_t'(2);
      3'd2:    gap = trial_t'(4);
      3'd3:    gap = trial_t'(2);
      3'd4:    gap = trial_t'(4);
      3'd5:    gap = trial_t'(6);
      3'd6:    gap = trial_t'(2);
      3'd7:    gap = trial_t'(6);
      default: gap = trial_t'(2);
    endcase
    return gap;
  endfunction

  // n-th prime (counting from 1), clamped to the table range
  function automatic trial_t prime_at(int n);
    bit [SIEVE_SIZE-1:0] sieve;
    int                  k;
    int                  cnt;
    int                  i;
    int                  j;
    trial_t              res;
    k = (n < 1) ? 1 : n;
    if (k >= TABLE_DEPTH) begin
      return LAST_PRIME;
    end
    sieve = '0;
    cnt   = 0;
    res   = FIRST_TRIAL;
    for (i = 2; i < SIEVE_SIZE && cnt < k; i++) begin
      if (!sieve[i]) begin
        cnt = cnt + 1;
        res = trial_t'(i);
        if (i < SIEVE_ROOT) begin
          for (j = i * i; j < SIEVE_SIZE; j += i) begin
            sieve[j] = 1'b1;
          end
        end
      end
    end
    return res;
  endfunction

endpackage

### rtl/pf_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on pf_pkg
`timescale 1ns / 1ps

module pf_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pf_pkg::value_t   dividend_i,
  input  pf_pkg::trial_t   divisor_i,
  output pf_pkg::div_res_t res_o
);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  pf_pkg::cnt_t   cnt_q, cnt_d;
  pf_pkg::trial_t rem_q, rem_d;
  pf_pkg::value_t sh_q, sh_d;

  logic [pf_pkg::TRIAL_W:0] part;
  logic [pf_pkg::TRIAL_W:0] diff;
  logic                     ge;

  always_comb begin
    part  = {rem_q, sh_q[pf_pkg::VALUE_W-1]};
    ge    = part >= {1'b0, divisor_i};
    diff  = part - {1'b0, divisor_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      sh_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[pf_pkg::TRIAL_W-1:0] : part[pf_pkg::TRIAL_W-1:0];
      sh_d  = {sh_q[pf_pkg::VALUE_W-2:0], ge};
      cnt_d = cnt_q + pf_pkg::cnt_t'(1);
      if (cnt_q == pf_pkg::cnt_t'(pf_pkg::VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign res_o.done  = done_q;
  assign res_o.exact = rem_q == '0;
  assign res_o.below = sh_q < {{(pf_pkg::VALUE_W - pf_pkg::TRIAL_W){1'b0}}, divisor_i};
  assign res_o.quo   = sh_q;

endmodule

### rtl/pf_trial_gen.sv
// trial divisor sequence: 2, 3, 5, then numbers coprime to 30
// depends on pf_pkg; last trial follows from PRIME_COUNT
`timescale 1ns / 1ps

module pf_trial_gen #(
  parameter int PRIME_COUNT = pf_pkg::PRIME_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pf_pkg::trial_ctrl_t ctrl_i,
  output pf_pkg::trial_t      trial_o,
  output logic                at_limit_o
);

  localparam pf_pkg::trial_t TrialLimit = pf_pkg::prime_at(PRIME_COUNT);

  pf_pkg::trial_t trial_q, trial_d;
  pf_pkg::wheel_t widx_q, widx_d;

  always_comb begin
    trial_d = trial_q;
    widx_d  = widx_q;
    if (ctrl_i.init) begin
      trial_d = pf_pkg::FIRST_TRIAL;
      widx_d  = '0;
    end else if (ctrl_i.step) begin
      if (trial_q < pf_pkg::WHEEL_START) begin
        // 2 -> 3 -> 5 -> 7
        trial_d = (trial_q == pf_pkg::FIRST_TRIAL) ? trial_q + pf_pkg::trial_t'(1)
                                                   : trial_q + pf_pkg::trial_t'(2);
      end else begin
        trial_d = trial_q + pf_pkg::wheel_step(widx_q);
        widx_d  = widx_q + pf_pkg::wheel_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trial_q <= pf_pkg::FIRST_TRIAL;
      widx_q  <= '0;
    end else begin
      trial_q <= trial_d;
      widx_q  <= widx_d;
    end
  end

  assign trial_o    = trial_q;
  assign at_limit_o = trial_q == TrialLimit;

endmodule

### rtl/prime_factorizer.sv
// Prime factorizer: one 32-bit unsigned value in, its prime factors out in
// ascending order, one transfer per factor (repeated per multiplicity), the
// last one flagged. Inputs 0 and 1 give one transfer with factor 0, last and
// no_factors set. Both channels use valid/stall; a transfer happens when valid
// is high and stall is low. in_stall_o is low only while the block is idle.
// Trials run 2, 3, 5 and then the numbers coprime to 30 up to the PRIME_COUNT-th
// prime, and stop early once the trial squared exceeds the remaining quotient.
// Each trial passes through the bit-serial divider: a start state, 32
// shift/subtract steps and a decision; an exact division repeats the trial
// after the ST_EMIT state hands the factor to the output register.
// Items are worked one at a time. A pending output transfer waits in the
// output register; while the receiver stalls, the walk halts before the next
// factor is handed over, and a new value may be taken once the walk is done.
// Reset clears the control state; nothing is pending afterward.
// Depends on pf_pkg, pf_trial_gen, pf_divider and prime_factorizer_assert.svh.
`timescale 1ns / 1ps

`include "prime_factorizer_assert.svh"

module prime_factorizer #(
  parameter int PRIME_COUNT = pf_pkg::PRIME_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pf_pkg::value_t value_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pf_pkg::value_t factor_o,
  output logic           last_o,
  output logic           no_factors_o
);

  pf_pkg::state_e      state_q, state_d;
  pf_pkg::value_t      q_q, q_d;
  pf_pkg::value_t      pend_factor_q, pend_factor_d;
  logic                pend_last_q, pend_last_d;
  logic                pend_nofac_q, pend_nofac_d;
  logic                out_valid_q;
  pf_pkg::value_t      factor_q;
  logic                last_q;
  logic                nofac_q;

  pf_pkg::trial_ctrl_t gen_ctrl;
  pf_pkg::trial_t      trial;
  logic                at_limit;
  logic                div_start;
  pf_pkg::div_res_t    div_res;
  logic                out_free;
  logic                out_load;

  pf_trial_gen #(
    .PRIME_COUNT(PRIME_COUNT)
  ) u_trial_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (gen_ctrl),
    .trial_o   (trial),
    .at_limit_o(at_limit)
  );

  pf_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(q_q),
    .divisor_i (trial),
    .res_o     (div_res)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    q_d           = q_q;
    pend_factor_d = pend_factor_q;
    pend_last_d   = pend_last_q;
    pend_nofac_d  = pend_nofac_q;
    gen_ctrl      = '0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      pf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (value_i <= pf_pkg::ONE_VALUE) begin
            pend_factor_d = '0;
            pend_last_d   = 1'b1;
            pend_nofac_d  = 1'b1;
            state_d       = pf_pkg::ST_EMIT;
          end else begin
            q_d           = value_i;
            gen_ctrl.init = 1'b1;
            state_d       = pf_pkg::ST_START;
          end
        end
      end
      pf_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = pf_pkg::ST_DIV;
      end
      pf_pkg::ST_DIV: begin
        if (div_res.done) begin
          if (div_res.exact) begin
            pend_factor_d = {{(pf_pkg::VALUE_W - pf_pkg::TRIAL_W){1'b0}}, trial};
            pend_last_d   = div_res.quo == pf_pkg::ONE_VALUE;
            pend_nofac_d  = 1'b0;
            q_d           = div_res.quo;
            state_d       = pf_pkg::ST_EMIT;
          end else if (div_res.below || at_limit) begin
            // leftover quotient is the final factor
            pend_factor_d = q_q;
            pend_last_d   = 1'b1;
            pend_nofac_d  = 1'b0;
            state_d       = pf_pkg::ST_EMIT;
          end else begin
            gen_ctrl.step = 1'b1;
            state_d       = pf_pkg::ST_START;
          end
        end
      end
      pf_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = pend_last_q ? pf_pkg::ST_IDLE : pf_pkg::ST_START;
        end
      end
      default: begin
        state_d = pf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q           <= q_d;
    pend_factor_q <= pend_factor_d;
    pend_last_q   <= pend_last_d;
    pend_nofac_q  <= pend_nofac_d;
    if (out_load) begin
      factor_q <= pend_factor_q;
      last_q   <= pend_last_q;
      nofac_q  <= pend_nofac_q;
    end
  end

  assign in_stall_o   = state_q != pf_pkg::ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign factor_o     = factor_q;
  assign last_o       = last_q;
  assign no_factors_o = nofac_q;

  `PF_ASSERT_IMPL(a_load_when_free, out_load, !out_valid_q || !out_stall_i, "output overwritten")
  `PF_ASSERT_IMPL(a_nofac_alone, out_valid_o && no_factors_o, last_o && factor_o == '0,
                  "no_factors transfer not alone")
  `PF_ASSERT_IMPL(a_done_in_div, div_res.done, state_q == pf_pkg::ST_DIV,
                  "divider result outside trial state")
  `PF_ASSERT_IMPL(a_trial_factor, out_valid_o && !last_o,
                  factor_o[pf_pkg::VALUE_W-1:pf_pkg::TRIAL_W] == '0 && factor_o > pf_pkg::ONE_VALUE,
                  "non-final factor not a trial divisor")
  `PF_ASSERT_NEXT(a_accept_moves, state_q == pf_pkg::ST_IDLE && in_valid_i,
                  state_q == pf_pkg::ST_START || state_q == pf_pkg::ST_EMIT,
                  "accepted value not started")

endmodule
